### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define MRB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MRB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mrb_pkg.sv
`default_nettype none

package mrb_pkg;

  localparam int NUM_MODES  = 32;
  localparam int MODE_AW    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int CNT_W      = $clog2(NUM_MODES + 1);

  localparam int CLIP_DEPTH = 1024;
  localparam int CLIP_AW    = $clog2(CLIP_DEPTH);

  // Beat layout
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int AMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int ACTIVE_W   = 6;
  localparam int IDX_W      = 5;
  localparam int Y_W        = 32;
  localparam int IN_TDATA_W = 96;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 16;

  // Shared multiplier
  localparam int MA_W       = 32;
  localparam int MB_W       = 18;
  localparam int PROD_W     = MA_W + MB_W;

  // Recursion sum: three 50-bit terms plus rounding bias
  localparam int S_W        = 53;
  localparam int Q_LSB      = 16;
  localparam int Q_MSB      = Q_LSB + Y_W - 1;

  // Weighted sum, clamp and gain split
  localparam int ACC_W      = 49 + MODE_AW;
  localparam int LIM_SH     = 43;
  localparam int ACCS_W     = LIM_SH + 2;
  localparam int ACC_LO_W   = 22;
  localparam int P_W        = 62;
  localparam int CLIP_SHIFT = LIM_SH - CLIP_AW;

  localparam longint SUM_LIM   = 64'sd1 <<< LIM_SH;
  localparam longint OFF_BIAS  = 64'sd1 <<< (LIM_SH - 1);
  localparam longint ROUND_HLF = 64'sd1 <<< (Q_LSB - 1);
  localparam longint Q30_ONE   = 64'sd1 <<< 30;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ACTIVE_MODES,
    CFG_MASTER_GAIN
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_RND,
    ST_FIN,
    ST_GLO,
    ST_GHI,
    ST_IDX,
    ST_ROM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] fb1;
    logic signed [COEF_W-1:0] fb2;
    logic signed [COEF_W-1:0] cin;
    logic        [AMP_W-1:0]  amp;
  } coef_t;

  typedef struct packed {
    logic signed [Y_W-1:0] y1;
    logic signed [Y_W-1:0] y2;
  } dly_t;

  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] x;
    logic        [CNT_W-1:0]    n;
    logic        [GAIN_W-1:0]   gain;
  } cmd_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } res_t;

  typedef logic signed [SAMPLE_W-1:0] clip_rom_t [CLIP_DEPTH];

  function automatic longint qmul30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // floor quotient of non-negative operands, shift and subtract
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int bt = 62; bt >= 0; bt--) begin
      r = (r <<< 1) | ((num >>> bt) & 64'sd1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // tanh over [-4,4): exp(-u) as a short Taylor series raised to the 256th power
  function automatic clip_rom_t clip_rom_fill();
    clip_rom_t rom;
    longint    d;
    longint    u;
    longint    term;
    longint    e;
    longint    num;
    longint    den;
    longint    r;
    bit        neg;
    for (int i = 0; i < CLIP_DEPTH; i++) begin
      d = 2 * longint'(i) - longint'(CLIP_DEPTH);
      neg = (d < 0);
      if (neg) begin
        d = -d;
      end
      u = (d <<< 25) >>> CLIP_AW;
      term = Q30_ONE;
      e = Q30_ONE;
      for (int k = 1; k <= 5; k++) begin
        term = udiv(qmul30(term, u), longint'(k));
        e = ((k & 1) == 1) ? e - term : e + term;
      end
      for (int k = 0; k < 8; k++) begin
        e = qmul30(e, e);
      end
      num = (Q30_ONE - e) <<< 15;
      den = Q30_ONE + e;
      r = 2 * num + den;
      // a negative numerator can only end at zero after the clamp
      r = (r < 0) ? 64'sd0 : udiv(r, 2 * den);
      if (r > 32767) begin
        r = 32767;
      end
      if (r < 0) begin
        r = 0;
      end
      rom[i] = SAMPLE_W'(neg ? -r : r);
    end
    return rom;
  endfunction

  localparam clip_rom_t CLIP_ROM = clip_rom_fill();

endpackage

`default_nettype wire

### design/mrb_mode_store.sv
`default_nettype none

// Per-mode coefficient and delay memories, registered read, valid bit per entry.
module mrb_mode_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         coef_we_i,
  input  logic [mrb_pkg::MODE_AW-1:0]  coef_waddr_i,
  input  mrb_pkg::coef_t               coef_wdata_i,
  input  logic                         dly_we_i,
  input  logic [mrb_pkg::MODE_AW-1:0]  dly_waddr_i,
  input  mrb_pkg::dly_t                dly_wdata_i,
  input  logic [mrb_pkg::MODE_AW-1:0]  rd_addr_i,
  output mrb_pkg::coef_t               coef_o,
  output mrb_pkg::dly_t                dly_o
);
  import mrb_pkg::*;

  coef_t coef_mem [NUM_MODES];
  dly_t  dly_mem  [NUM_MODES];

  logic [NUM_MODES-1:0] coef_vld_q;
  logic [NUM_MODES-1:0] dly_vld_q;
  coef_t                coef_rd_q;
  dly_t                 dly_rd_q;
  logic                 coef_hit_q;
  logic                 dly_hit_q;

  always_ff @(posedge clk_i) begin
    if (coef_we_i) begin
      coef_mem[coef_waddr_i] <= coef_wdata_i;
    end
    if (dly_we_i) begin
      dly_mem[dly_waddr_i] <= dly_wdata_i;
    end
    coef_rd_q <= coef_mem[rd_addr_i];
    dly_rd_q  <= dly_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      dly_vld_q  <= '0;
      coef_hit_q <= 1'b0;
      dly_hit_q  <= 1'b0;
    end else begin
      if (coef_we_i) begin
        coef_vld_q[coef_waddr_i] <= 1'b1;
      end
      if (dly_we_i) begin
        dly_vld_q[dly_waddr_i] <= 1'b1;
      end
      coef_hit_q <= coef_vld_q[rd_addr_i];
      dly_hit_q  <= dly_vld_q[rd_addr_i];
    end
  end

  // never-written entries read as zero
  assign coef_o = coef_hit_q ? coef_rd_q : '0;
  assign dly_o  = dly_hit_q  ? dly_rd_q  : '0;

endmodule

`default_nettype wire

### design/mrb_mult.sv
`default_nettype none

// Shared signed multiplier, product registered.
module mrb_mult (
  input  logic                               clk_i,
  input  logic signed [mrb_pkg::MA_W-1:0]    a_i,
  input  logic signed [mrb_pkg::MB_W-1:0]    b_i,
  output logic signed [mrb_pkg::PROD_W-1:0]  prod_o
);
  import mrb_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### design/mrb_clip_rom.sv
`default_nettype none

// tanh soft-clip table, registered read.
module mrb_clip_rom (
  input  logic                                clk_i,
  input  logic        [mrb_pkg::CLIP_AW-1:0]  addr_i,
  output logic signed [mrb_pkg::SAMPLE_W-1:0] data_o
);
  import mrb_pkg::*;

  logic signed [SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= CLIP_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

### design/mrb_seq.sv
`default_nettype none

// Sample sequencer: walks the modes through the shared multiplier, then the gain and clip.
module mrb_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mrb_pkg::cmd_t                cmd_i,
  input  logic                         out_free_i,
  input  mrb_pkg::coef_t               coef_i,
  input  mrb_pkg::dly_t                dly_i,
  output logic [mrb_pkg::MODE_AW-1:0]  rd_addr_o,
  output logic                         dly_we_o,
  output logic [mrb_pkg::MODE_AW-1:0]  dly_waddr_o,
  output mrb_pkg::dly_t                dly_wdata_o,
  output logic                         idle_o,
  output mrb_pkg::res_t                res_o
);
  import mrb_pkg::*;

  state_e                     state_q, state_d;
  logic [MODE_AW-1:0]         k_q;
  logic [CNT_W-1:0]           n_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [S_W-1:0]      s_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       pend_q;
  logic                       sat_q;
  logic signed [PROD_W-1:0]   plo_q;
  logic [CLIP_AW-1:0]         idx_q;

  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] rom_data;

  logic [MODE_AW-1:0]         k_inc;
  logic                       last;
  logic                       skip;
  logic signed [S_W-1:0]      t_sum;
  logic                       sat_now;
  logic signed [Y_W-1:0]      q_val;
  logic signed [ACC_W-1:0]    lim_p;
  logic signed [ACC_W-1:0]    lim_n;
  logic signed [ACCS_W-1:0]   accs;
  logic signed [P_W-1:0]      p_sum;
  logic signed [P_W-1:0]      off;
  logic [CLIP_AW-1:0]         idx_d;

  mrb_mult u_mult (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  mrb_clip_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (idx_q),
    .data_o (rom_data)
  );

  assign k_inc = k_q + 1'b1;
  assign last  = (CNT_W'(k_q) + CNT_W'(1)) == n_q;
  assign skip  = (coef_i.amp == '0);

  // y = a1*y1 + a2*y2 + 2*b0*x + half, floor by 2^16, saturate to 32 bits
  assign t_sum   = s_q + (S_W'(prod) <<< 1);
  assign sat_now = !((&t_sum[S_W-1:Q_MSB]) || (~|t_sum[S_W-1:Q_MSB]));
  always_comb begin
    if (!sat_now) begin
      q_val = t_sum[Q_MSB:Q_LSB];
    end else if (t_sum[S_W-1]) begin
      q_val = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      q_val = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  assign lim_p = ACC_W'(SUM_LIM);
  assign lim_n = ACC_W'(-SUM_LIM);
  always_comb begin
    if (acc_q > lim_p) begin
      accs = ACCS_W'(lim_p);
    end else if (acc_q < lim_n) begin
      accs = ACCS_W'(lim_n);
    end else begin
      accs = ACCS_W'(acc_q);
    end
  end

  // gain product from two partial products, then offset into the table range
  assign p_sum = (P_W'(prod) <<< ACC_LO_W) + P_W'(plo_q);
  assign off   = p_sum + P_W'(OFF_BIAS);
  always_comb begin
    if (off[P_W-1]) begin
      idx_d = '0;
    end else if (|off[P_W-2:LIM_SH]) begin
      idx_d = '1;
    end else begin
      idx_d = off[LIM_SH-1:CLIP_SHIFT];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (skip) begin
          state_d = last ? ST_FIN : ST_MUL1;
        end else begin
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_RND;
      ST_RND:  state_d = last ? ST_FIN : ST_MUL1;
      ST_FIN:  state_d = ST_GLO;
      ST_GLO:  state_d = ST_GHI;
      ST_GHI:  state_d = ST_IDX;
      ST_IDX:  state_d = ST_ROM;
      ST_ROM:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    rd_addr_o   = k_q;
    dly_we_o    = 1'b0;
    dly_waddr_o = k_q;
    dly_wdata_o = '{y1: q_val, y2: dly_i.y1};
    res_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr_o = '0;
      end
      ST_MUL1: begin
        mul_a = dly_i.y1;
        mul_b = coef_i.fb1;
        if (skip) begin
          rd_addr_o = k_inc;
        end
      end
      ST_MUL2: begin
        mul_a = dly_i.y2;
        mul_b = coef_i.fb2;
      end
      ST_MUL3: begin
        mul_a = MA_W'(x_q);
        mul_b = coef_i.cin;
      end
      ST_RND: begin
        mul_a     = q_val;
        mul_b     = MB_W'(coef_i.amp);
        rd_addr_o = k_inc;
        dly_we_o  = 1'b1;
      end
      ST_GLO: begin
        mul_a = MA_W'(accs[ACC_LO_W-1:0]);
        mul_b = MB_W'(gain_q);
      end
      ST_GHI: begin
        mul_a = MA_W'($signed(accs[ACCS_W-1:ACC_LO_W]));
        mul_b = MB_W'(gain_q);
      end
      ST_OUT: begin
        res_o.valid  = out_free_i;
        res_o.sample = (gain_q == '0) ? '0 : rom_data;
        res_o.sat    = sat_q;
      end
      ST_FIN, ST_IDX, ST_ROM: begin
      end
      default: begin
      end
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      n_q     <= '0;
      pend_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == ST_RND);
      if (state_q == ST_IDLE && cmd_i.start) begin
        k_q   <= '0;
        n_q   <= cmd_i.n;
        sat_q <= 1'b0;
      end else if ((state_q == ST_MUL1 && skip && !last) || (state_q == ST_RND && !last)) begin
        k_q <= k_inc;
      end
      if (state_q == ST_RND) begin
        sat_q <= sat_q | sat_now;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_i.start) begin
      x_q    <= cmd_i.x;
      gain_q <= cmd_i.gain;
      acc_q  <= '0;
    end else if (pend_q) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
    if (state_q == ST_MUL2) begin
      s_q <= S_W'(prod) + S_W'(ROUND_HLF);
    end else if (state_q == ST_MUL3) begin
      s_q <= s_q + S_W'(prod);
    end
    if (state_q == ST_GHI) begin
      plo_q <= prod;
    end
    if (state_q == ST_IDX) begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

### design/modal_resonator_bank.sv
`default_nettype none

// Channel    Dir  Handshake                   Payload
// s_axis     in   s_axis_tvalid/tready        tdata: sample_in, mode_index, coef_fb1,
//                                             coef_fb2, coef_in, mode_amp; tuser: func
// m_axis     out  m_axis_tvalid/tready        tdata: sample_out; tuser: state_saturated
// cfg        in   cfg_we_i (no back-pressure) cfg_idx_i, cfg_wdata_i
//
// A load beat (func set) is written straight into the mode store; the input stays ready.
// A sample beat holds the input not ready until the sequencer is idle again. Each mode with
// nonzero amplitude takes three recursion products and one weighting product on the single
// registered multiplier, a mode with zero amplitude is skipped, and two gain partial
// products follow the last mode.
// Reset clears the mode stores through per-entry valid bits at once; no clearing pass.
// A result held in the output register stalls the sequencer in its last state only.
module modal_resonator_bank (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // s_axis_tdata, low bit up: sample_in[15:0], mode_index[20:16], coef_fb1[38:21],
  // coef_fb2[56:39], coef_in[74:57], mode_amp[90:75], zero pad[95:91]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: func[0]
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // m_axis_tdata: sample_out[15:0]
  output logic [mrb_pkg::SAMPLE_W-1:0]       m_axis_tdata,
  // m_axis_tuser: state_saturated[0]
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_we_i,
  input  mrb_pkg::cfg_idx_e                  cfg_idx_i,
  input  logic [mrb_pkg::CFG_DW-1:0]         cfg_wdata_i
);
  import mrb_pkg::*;

  // configuration
  logic [ACTIVE_W-1:0] active_q;
  logic [GAIN_W-1:0]   gain_q;

  // input beat fields
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [IDX_W-1:0]           in_index;
  coef_t                      in_coef;
  logic                       in_load;
  logic                       beat_in;

  logic [CNT_W-1:0] n_clamped;
  cmd_t             cmd;
  res_t             res;
  logic             seq_idle;
  logic             out_free;

  coef_t              coef_rd;
  dly_t               dly_rd;
  logic [MODE_AW-1:0] rd_addr;
  logic               dly_we;
  logic [MODE_AW-1:0] dly_waddr;
  dly_t               dly_wdata;
  logic               coef_we;

  logic                       m_valid_q;
  logic signed [SAMPLE_W-1:0] m_sample_q;
  logic                       m_sat_q;

  assign in_sample   = s_axis_tdata[15:0];
  assign in_index    = s_axis_tdata[20:16];
  assign in_coef.fb1 = s_axis_tdata[38:21];
  assign in_coef.fb2 = s_axis_tdata[56:39];
  assign in_coef.cin = s_axis_tdata[74:57];
  assign in_coef.amp = s_axis_tdata[90:75];
  assign in_load     = s_axis_tuser[0];

  assign s_axis_tready = seq_idle;
  assign beat_in       = s_axis_tvalid && s_axis_tready;

  // entries beyond the bank are dropped
  assign coef_we = beat_in && in_load && (int'(in_index) < NUM_MODES);

  // zero active modes acts as one, too many as the full bank
  always_comb begin
    if (active_q == '0) begin
      n_clamped = CNT_W'(1);
    end else if (int'(active_q) > NUM_MODES) begin
      n_clamped = CNT_W'(NUM_MODES);
    end else begin
      n_clamped = CNT_W'(active_q);
    end
  end

  assign cmd.start = beat_in && !in_load;
  assign cmd.x     = in_sample;
  assign cmd.n     = n_clamped;
  assign cmd.gain  = gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_W'(10);
      gain_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_MODES: active_q <= cfg_wdata_i[ACTIVE_W-1:0];
        CFG_MASTER_GAIN:  gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mrb_mode_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_we_i    (coef_we),
    .coef_waddr_i (MODE_AW'(in_index)),
    .coef_wdata_i (in_coef),
    .dly_we_i     (dly_we),
    .dly_waddr_i  (dly_waddr),
    .dly_wdata_i  (dly_wdata),
    .rd_addr_i    (rd_addr),
    .coef_o       (coef_rd),
    .dly_o        (dly_rd)
  );

  mrb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .out_free_i  (out_free),
    .coef_i      (coef_rd),
    .dly_i       (dly_rd),
    .rd_addr_o   (rd_addr),
    .dly_we_o    (dly_we),
    .dly_waddr_o (dly_waddr),
    .dly_wdata_o (dly_wdata),
    .idle_o      (seq_idle),
    .res_o       (res)
  );

  // output register: free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      m_sample_q <= res.sample;
      m_sat_q    <= res.sat;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_sample_q;
  assign m_axis_tuser[0] = m_sat_q;

endmodule

`default_nettype wire

### design/mrb_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the resonator bank.
module mrb_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [0:0]                     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [mrb_pkg::SAMPLE_W-1:0]   m_axis_tdata,
  input  logic [0:0]                     m_axis_tuser
);

  // a stalled result beat holds
  `MRB_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat dropped or changed under stall")

  // a sample beat busies the input straight away
  `MRB_ASSERT(a_busy_after_sample, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !s_axis_tready, "input still ready after a sample beat")

  // a result only appears at the end of a busy sample period
  `MRB_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared while input was idle")

  // reset empties the output register
  `MRB_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni ##1 !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind modal_resonator_bank mrb_checker u_mrb_checker (.*);

`default_nettype wire

### dv/modal_resonator_bank_tb.sv
`timescale 1ns / 100ps

module modal_resonator_bank_tb;
  import mrb_pkg::*;

  // Longer than the worst sample beat; used as the quiet spell before a register write
  localparam int     BUSY_CYCLES     = 150;
  localparam int     ACTIVE_AT_RESET = 10;
  localparam int     NUM_PHASES      = 8;
  localparam int     PHASE_BEATS     = 220;
  localparam int     RX_HOLD_CYCLES  = 4000;
  localparam int     PRINT_CAP       = 200;
  localparam int     LUT_SHIFT       = 43 - $clog2(CLIP_DEPTH);
  localparam longint ACC_CLAMP       = 64'sd1 <<< 43;
  localparam longint Y_HI            = (64'sd1 <<< 31) - 1;
  localparam longint Y_LO            = -(64'sd1 <<< 31);
  localparam longint Q30_UNIT        = 64'sd1 <<< 30;
  // index past the register list, must be ignored
  localparam logic [CFG_IW-1:0] CFG_UNMAPPED = 2'd3;

  // One input beat, unpacked; load set means a mode table write
  typedef struct {
    logic                       load;
    logic signed [SAMPLE_W-1:0] sample;
    logic        [IDX_W-1:0]    mode;
    logic signed [COEF_W-1:0]   fb1;
    logic signed [COEF_W-1:0]   fb2;
    logic signed [COEF_W-1:0]   cin;
    logic        [AMP_W-1:0]    amp;
  } beat_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } voice_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  cfg_idx_e              cfg_idx_i     = CFG_ACTIVE_MODES;
  logic [CFG_DW-1:0]     cfg_wdata_i   = '0;

  modal_resonator_bank dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predicted bank state: coefficient tables, Q16.16 delay lines, registers
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0]   a1_tab  [NUM_MODES];
  logic signed [COEF_W-1:0]   a2_tab  [NUM_MODES];
  logic signed [COEF_W-1:0]   b0_tab  [NUM_MODES];
  logic        [AMP_W-1:0]    amp_tab [NUM_MODES];
  logic signed [Y_W-1:0]      y1_mem  [NUM_MODES];
  logic signed [Y_W-1:0]      y2_mem  [NUM_MODES];
  logic        [ACTIVE_W-1:0] active_reg;
  logic        [GAIN_W-1:0]   gain_reg;
  logic signed [SAMPLE_W-1:0] tanh_lut [CLIP_DEPTH];

  beat_t  pending_beats [$];
  voice_t expected_out  [$];
  beat_t  on_bus;
  voice_t head;
  bit     in_taken     = 1'b0;
  int     beats_queued = 0;
  int     beats_taken  = 0;
  int     mismatches   = 0;
  int     tx_idle_pct  = 35;
  int     rx_idle_pct  = 47;
  int     rx_hold_request = 0;
  int     rx_hold_left    = 0;

  int phase_active [NUM_PHASES] = '{0, 32, 1, 63, 17, 32, 5, 32};
  int phase_gain   [NUM_PHASES] = '{4096, 65535, 1, 0, 12000, 300, 2048, 40000};

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Soft clip table: exp(-t) from a five-term series at t/256, squared eight times,
  // then tanh = (1 - e) / (1 + e) rounded half up, odd about the centre entry
  function automatic void build_tanh_lut();
    longint mag;
    longint u;
    longint term;
    longint e;
    longint num;
    longint den;
    longint r;
    for (int i = 0; i < CLIP_DEPTH; i++) begin
      mag = 2 * i - CLIP_DEPTH;
      if (mag < 0) begin
        mag = -mag;
      end
      u    = (mag <<< 25) / CLIP_DEPTH;
      term = Q30_UNIT;
      e    = Q30_UNIT;
      for (int k = 1; k <= 5; k++) begin
        term = q30_product(term, u) / k;
        if (k % 2 == 1) begin
          e = e - term;
        end else begin
          e = e + term;
        end
      end
      repeat (8) e = q30_product(e, e);
      num = (Q30_UNIT - e) <<< 15;
      den = Q30_UNIT + e;
      r   = (2 * num + den) / (2 * den);
      if (r > 32767) begin
        r = 32767;
      end
      if (r < 0) begin
        r = 0;
      end
      tanh_lut[i] = SAMPLE_W'((2 * i < CLIP_DEPTH) ? -r : r);
    end
  endfunction

  // Advance the bank by one accepted beat; a sample beat leaves one expected voice
  function automatic void bank_step(input beat_t b);
    int     n;
    int     idx;
    longint s;
    longint q;
    longint acc;
    longint off;
    voice_t v;
    if (b.load) begin
      a1_tab[b.mode]  = b.fb1;
      a2_tab[b.mode]  = b.fb2;
      b0_tab[b.mode]  = b.cin;
      amp_tab[b.mode] = b.amp;
      return;
    end
    // zero runs one mode, anything past the bank runs all of them
    if (active_reg == '0) begin
      n = 1;
    end else if (active_reg > NUM_MODES) begin
      n = NUM_MODES;
    end else begin
      n = int'(active_reg);
    end
    acc   = 0;
    v.sat = 1'b0;
    for (int k = 0; k < n; k++) begin
      // silent modes are skipped and keep their delay lines
      if (amp_tab[k] != '0) begin
        s = longint'(a1_tab[k]) * longint'(y1_mem[k])
          + longint'(a2_tab[k]) * longint'(y2_mem[k])
          + 2 * longint'(b0_tab[k]) * longint'(b.sample);
        q = (s + (64'sd1 <<< 15)) >>> 16;
        if (q > Y_HI) begin
          q     = Y_HI;
          v.sat = 1'b1;
        end else if (q < Y_LO) begin
          q     = Y_LO;
          v.sat = 1'b1;
        end
        y2_mem[k] = y1_mem[k];
        y1_mem[k] = q[Y_W-1:0];
        acc += longint'(amp_tab[k]) * q;
      end
    end
    if (acc > ACC_CLAMP) begin
      acc = ACC_CLAMP;
    end else if (acc < -ACC_CLAMP) begin
      acc = -ACC_CLAMP;
    end
    if (gain_reg == '0) begin
      v.sample = '0;
    end else begin
      // shift the product by half the table span so entry 0 sits at -4
      off = acc * longint'(gain_reg) + (ACC_CLAMP >>> 1);
      if (off < 0) begin
        idx = 0;
      end else if (off >= ACC_CLAMP) begin
        idx = CLIP_DEPTH - 1;
      end else begin
        idx = int'(off >>> LUT_SHIFT);
      end
      v.sample = tanh_lut[idx];
    end
    expected_out.push_back(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------
  function automatic beat_t mode_beat(input int m, input int a1, input int a2, input int b0,
                                      input int amp);
    beat_t b;
    b.load   = 1'b1;
    b.sample = SAMPLE_W'($urandom);
    b.mode   = m[IDX_W-1:0];
    b.fb1    = a1[COEF_W-1:0];
    b.fb2    = a2[COEF_W-1:0];
    b.cin    = b0[COEF_W-1:0];
    b.amp    = amp[AMP_W-1:0];
    return b;
  endfunction

  // unused fields of a sample beat carry junk; the block must ignore them
  function automatic beat_t sample_beat(input logic signed [SAMPLE_W-1:0] x);
    beat_t b;
    b        = mode_beat($urandom, $urandom, $urandom, $urandom, $urandom);
    b.load   = 1'b0;
    b.sample = x;
    return b;
  endfunction

  // Decaying resonator: a2 = -r^2 and |a1| < 1 + r^2 keeps both poles inside the circle
  function automatic beat_t tuned_mode(input int m);
    int pull;
    int a1;
    int b0;
    pull = $urandom_range(65500, 30000);
    a1   = $urandom_range(65535 + pull, 0);
    b0   = $urandom_range(4096, 0);
    if ($urandom_range(1, 0) == 1) begin
      a1 = -a1;
    end
    if ($urandom_range(1, 0) == 1) begin
      b0 = -b0;
    end
    return mode_beat(m, a1, -pull, b0,
                     ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(65535, 1));
  endfunction

  function automatic void enqueue(input beat_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    // keep the log readable when the block is badly off
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Wait out every queued beat and every result, then let the sequencer go idle
  task automatic go_quiet();
    while (beats_taken != beats_queued || expected_out.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (BUSY_CYCLES) @(negedge clk_i);
  endtask

  // Only called with the bank idle, so the predictor can follow at once
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ACTIVE_MODES: active_reg = val[ACTIVE_W-1:0];
      CFG_MASTER_GAIN:  gain_reg   = val[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: a new beat only once the previous one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_beats.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        on_bus = pending_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({on_bus.amp, on_bus.cin, on_bus.fb2, on_bus.fb1,
                                      on_bus.mode, on_bus.sample});
        s_axis_tuser  <= on_bus.load;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_request != 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input beat taken, check every output beat taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        bank_step(on_bus);
        beats_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("output beat with none expected, sample_out %0d",
                                    $signed(m_axis_tdata)));
        end else begin
          head = expected_out.pop_front();
          if (m_axis_tdata !== head.sample) begin
            report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                      $signed(m_axis_tdata), head.sample));
          end
          if (m_axis_tuser[0] !== head.sat) begin
            report_mismatch($sformatf("state_saturated %0b, predicted %0b",
                                      m_axis_tuser[0], head.sat));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int                         roll;
    logic signed [SAMPLE_W-1:0] x;
    build_tanh_lut();
    for (int k = 0; k < NUM_MODES; k++) begin
      a1_tab[k]  = '0;
      a2_tab[k]  = '0;
      b0_tab[k]  = '0;
      amp_tab[k] = '0;
      y1_mem[k]  = '0;
      y2_mem[k]  = '0;
    end
    active_reg = ACTIVE_W'(ACTIVE_AT_RESET);
    gain_reg   = '0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // straight after reset every mode is silent and the gain mutes the output
    enqueue(sample_beat(16'sh7FFF));
    // runaway mode, heads for positive saturation and the top of the table
    enqueue(mode_beat(0, 131071, 131071, 131071, 65535));
    // alternating runaway at the last entry, smallest weight
    enqueue(mode_beat(31, -131072, 131071, -131072, 1));
    // all-ones coefficients but zero weight: must stay frozen
    enqueue(mode_beat(9, -1, -1, -1, 0));
    // plain pass-through at unity weight
    enqueue(mode_beat(3, 0, 0, 65536, 4096));
    go_quiet();
    write_reg(CFG_ACTIVE_MODES, CFG_DW'(NUM_MODES));
    write_reg(CFG_MASTER_GAIN, 16'hFFFF);
    write_reg(cfg_idx_e'(CFG_UNMAPPED), 16'h0001);
    for (int i = 0; i < 12; i++) begin
      enqueue(sample_beat((i == 1) ? 16'sh8000 : (i == 2) ? 16'sh0000 : 16'sh7FFF));
    end
    go_quiet();
    // a zero count still runs one mode; the weighted sum hits its clamp
    write_reg(CFG_ACTIVE_MODES, 16'h0000);
    write_reg(CFG_MASTER_GAIN, 16'h0001);
    for (int i = 0; i < 3; i++) begin
      enqueue(sample_beat(SAMPLE_W'($urandom)));
    end
    go_quiet();
    // top bits of the write are dropped, 63 runs the whole bank; gain muted
    write_reg(CFG_ACTIVE_MODES, 16'hFFFF);
    write_reg(CFG_MASTER_GAIN, 16'h0000);
    enqueue(sample_beat(16'sh8000));
    enqueue(sample_beat(16'sh0001));

    // --- random phases ---
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      go_quiet();
      write_reg(CFG_ACTIVE_MODES, CFG_DW'({$urandom, ACTIVE_W'(phase_active[ph])}));
      write_reg(CFG_MASTER_GAIN, CFG_DW'(phase_gain[ph]));
      @(posedge clk_i);
      if (ph < 3) begin
        tx_idle_pct = 35;
        rx_idle_pct = 47;
      end else if (ph < 6) begin
        tx_idle_pct = 47;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // receiver goes away for a long spell while beats keep coming
      if (ph == 1) begin
        rx_hold_request = RX_HOLD_CYCLES;
      end
      // retune the whole bank, then mostly samples with the odd mode rewrite
      for (int m = 0; m < NUM_MODES; m++) begin
        enqueue(tuned_mode(m));
      end
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // sender holds back until the bank has caught up
        if (ph == 4 && i == PHASE_BEATS / 2) begin
          go_quiet();
        end
        roll = $urandom_range(99, 0);
        if (roll < 5) begin
          enqueue(tuned_mode($urandom_range(NUM_MODES - 1, 0)));
        end else if (roll < 8) begin
          // any coefficients at all, usually unstable
          enqueue(mode_beat($urandom, $urandom, $urandom, $urandom, $urandom));
        end else begin
          roll = $urandom_range(99, 0);
          if (roll < 25) begin
            x = '0;
          end else if (roll < 85) begin
            x = SAMPLE_W'($urandom_range(4095, 0) - 2048);
          end else begin
            x = SAMPLE_W'($urandom);
          end
          enqueue(sample_beat(x));
        end
      end
    end

    go_quiet();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Safety net, several times the slowest legal run
  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
